@@ sv/kbsc_pkg.sv @@
// Shared types, key codes and key maps for the set-1 scancode decoder.
package kbsc_pkg;

    localparam int MAP_LEN = 58;

    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_UP     = 7'h48;
    localparam logic [6:0] KEY_DOWN   = 7'h50;
    localparam logic [6:0] KEY_LEFT   = 7'h4B;
    localparam logic [6:0] KEY_RIGHT  = 7'h4D;

    localparam logic [6:0] ASCII_NUL    = 7'h00;
    localparam logic [6:0] ASCII_BS     = 7'h08;
    localparam logic [6:0] ASCII_LF     = 7'h0A;
    localparam logic [6:0] ASCII_LOW_A  = 7'h61;
    localparam logic [6:0] ASCII_LOW_Z  = 7'h7A;
    localparam logic [6:0] ASCII_UP_A   = 7'h41;
    localparam logic [6:0] ASCII_UP_Z   = 7'h5A;
    localparam logic [6:0] CASE_DELTA   = 7'd32;

    typedef enum logic [2:0] {
        EV_CHAR      = 3'd0,
        EV_BACKSPACE = 3'd1,
        EV_ENTER     = 3'd2,
        EV_LEFT      = 3'd3,
        EV_RIGHT     = 3'd4
    } ev_kind_t;

    typedef struct packed {
        logic caps_lock;
        logic shift_down;
        logic ctrl_down;
        logic alt_down;
    } flags_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [6:0] char_code;
        logic       ctrl_held;
        logic       alt_held;
    } result_t;

    localparam logic [6:0] PLAIN_MAP [MAP_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
        7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [6:0] SHIFT_MAP [MAP_LEN] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
        7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

endpackage

@@ sv/keyboard_scancode_to_char_top.sv @@
// Top level of the set-1 keyboard scancode to character decoder.
// Takes one raw set-1 scancode beat per cycle while in_ready is high and returns
// at most one event beat per scancode: a character, backspace, enter, or cursor
// left/right, together with the current ctrl and alt state. Modifier and caps
// lock scancodes update internal flags; these, release and up/down scancodes
// produce no beat. A scancode is captured in an input register, decoded
// combinationally against the modifier flags and written to the result register;
// a new scancode can be accepted every cycle unless the input side stalls. The
// result register holds a beat while out_ready is low; the input side then stalls
// only when the registered scancode would itself produce an event.
module keyboard_scancode_to_char_top
    import kbsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] scancode,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_kind,
    output logic [6:0] char_code,
    output logic       ctrl_held,
    output logic       alt_held
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_code_reg;
    flags_t     flags_reg;
    flags_t     flags_next;
    logic       has_result;
    result_t    dec_result;
    result_t    out_result;
    logic       out_space;
    logic       s1_adv;

    kbsc_decode u_decode (
        .scancode   (s1_code_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .has_result (has_result),
        .result     (dec_result)
    );

    assign s1_adv   = s1_valid_reg & (~has_result | out_space);
    assign in_ready = ~s1_valid_reg | s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_code_reg <= scancode;
        end
    end

    kbsc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_adv & has_result),
        .result     (dec_result),
        .space      (out_space),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_result (out_result)
    );

    assign event_kind = out_result.kind;
    assign char_code  = out_result.char_code;
    assign ctrl_held  = out_result.ctrl_held;
    assign alt_held   = out_result.alt_held;

endmodule

@@ sv/kbsc_decode.sv @@
// Combinational decode of one scancode: modifier flag update and event lookup.
module kbsc_decode
    import kbsc_pkg::*;
(
    input  logic [7:0] scancode,
    input  flags_t     flags,
    output flags_t     flags_next,
    output logic       has_result,
    output result_t    result
);

    logic [6:0] key;
    logic [6:0] map_char;
    logic [6:0] c;

    assign key = scancode[6:0];

    always_comb
    begin
        if (key < 7'(MAP_LEN))
        begin
            map_char = flags.shift_down ? SHIFT_MAP[key[5:0]] : PLAIN_MAP[key[5:0]];
        end
        else
        begin
            map_char = ASCII_NUL;
        end
        // caps lock flips letter case after the shift map is applied
        c = map_char;
        if (flags.caps_lock)
        begin
            if (map_char >= ASCII_LOW_A && map_char <= ASCII_LOW_Z)
            begin
                c = map_char - CASE_DELTA;
            end
            else if (map_char >= ASCII_UP_A && map_char <= ASCII_UP_Z)
            begin
                c = map_char + CASE_DELTA;
            end
        end
    end

    always_comb
    begin
        flags_next       = flags;
        has_result       = 1'b0;
        result.kind      = EV_CHAR;
        result.char_code = ASCII_NUL;
        if (scancode[7])
        begin
            if (key == KEY_LSHIFT || key == KEY_RSHIFT)
            begin
                flags_next.shift_down = 1'b0;
            end
            else if (key == KEY_CTRL)
            begin
                flags_next.ctrl_down = 1'b0;
            end
            else if (key == KEY_ALT)
            begin
                flags_next.alt_down = 1'b0;
            end
        end
        else
        begin
            case (key)
                KEY_UP, KEY_DOWN:
                begin
                end
                KEY_LEFT:
                begin
                    has_result  = 1'b1;
                    result.kind = EV_LEFT;
                end
                KEY_RIGHT:
                begin
                    has_result  = 1'b1;
                    result.kind = EV_RIGHT;
                end
                KEY_LSHIFT, KEY_RSHIFT:
                begin
                    flags_next.shift_down = 1'b1;
                end
                KEY_CTRL:
                begin
                    flags_next.ctrl_down = 1'b1;
                end
                KEY_ALT:
                begin
                    flags_next.alt_down = 1'b1;
                end
                KEY_CAPS:
                begin
                    flags_next.caps_lock = ~flags.caps_lock;
                end
                default:
                begin
                    if (c == ASCII_BS)
                    begin
                        has_result  = 1'b1;
                        result.kind = EV_BACKSPACE;
                    end
                    else if (c == ASCII_LF)
                    begin
                        has_result  = 1'b1;
                        result.kind = EV_ENTER;
                    end
                    else if (c != ASCII_NUL)
                    begin
                        has_result       = 1'b1;
                        result.kind      = EV_CHAR;
                        result.char_code = c;
                    end
                end
            endcase
        end
        // events never change modifiers, so the current flags are the post-item flags
        result.ctrl_held = flags.ctrl_down;
        result.alt_held  = flags.alt_down;
    end

endmodule

@@ sv/kbsc_out_stage.sv @@
// Result register with valid/ready handshake toward the consumer.
module kbsc_out_stage
    import kbsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    space,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // a new beat may land when empty or when the held one leaves this cycle
    assign space = ~valid_reg | out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

endmodule

@@ sv/kbsc_checker.sv @@
// Port-level checker for the scancode decoder, bound to the top level.
module kbsc_checker
    import kbsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] scancode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_kind,
    input logic [6:0] char_code,
    input logic       ctrl_held,
    input logic       alt_held
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(char_code) && $stable(ctrl_held) && $stable(alt_held))
        else $error("result beat changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == EV_CHAR || event_kind == EV_BACKSPACE
            || event_kind == EV_ENTER || event_kind == EV_LEFT
            || event_kind == EV_RIGHT))
        else $error("event kind out of range");

    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_CHAR |-> char_code == ASCII_NUL)
        else $error("non-character event with nonzero code");

    // backspace and enter never leak out as character beats
    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_CHAR |-> char_code != ASCII_NUL
            && char_code != ASCII_BS && char_code != ASCII_LF)
        else $error("character beat with control code");

endmodule

bind keyboard_scancode_to_char_top kbsc_checker u_kbsc_checker (.*);

@@ tb/sv/keyboard_scancode_to_char_top_test.sv @@
// Self-checking testbench for the set-1 keyboard scancode to character decoder.
`timescale 1ns / 1ps

module keyboard_scancode_to_char_top_test
    import kbsc_pkg::*;
;

    localparam int N_RANDOM = 1950;
    localparam int MAP_SIZE = 58;

    class kb_event_scoreboard;
        bit         caps_on;
        bit         shift_on;
        bit         ctrl_on;
        bit         alt_on;
        bit [6:0]   plain_tbl [MAP_SIZE];
        bit [6:0]   shift_tbl [MAP_SIZE];
        result_t    expected_events [$];
        int         errors;

        function new();
            caps_on  = 1'b0;
            shift_on = 1'b0;
            ctrl_on  = 1'b0;
            alt_on   = 1'b0;
            errors   = 0;
            plain_tbl = '{
                7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
                7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
                7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
                7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
                7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
                7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
                7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
                7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
            };
            shift_tbl = '{
                7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
                7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
                7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
                7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
                7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
                7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
                7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
                7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
            };
        endfunction

        function void push_event(ev_kind_t kind, logic [6:0] code);
            result_t ev;
            ev.kind      = kind;
            ev.char_code = code;
            ev.ctrl_held = ctrl_on;
            ev.alt_held  = alt_on;
            expected_events.push_back(ev);
        endfunction

        // Update the key flags for one accepted scancode and queue its event, if any.
        function void note_scancode(logic [7:0] sc);
            logic [6:0] key;
            logic [6:0] ch;
            key = sc[6:0];
            if (sc[7]) begin
                if (key == KEY_LSHIFT || key == KEY_RSHIFT)
                    shift_on = 1'b0;
                else if (key == KEY_CTRL)
                    ctrl_on = 1'b0;
                else if (key == KEY_ALT)
                    alt_on = 1'b0;
                return;
            end
            case (key)
                KEY_UP, KEY_DOWN: return;
                KEY_LEFT:
                begin
                    push_event(EV_LEFT, ASCII_NUL);
                    return;
                end
                KEY_RIGHT:
                begin
                    push_event(EV_RIGHT, ASCII_NUL);
                    return;
                end
                KEY_LSHIFT, KEY_RSHIFT:
                begin
                    shift_on = 1'b1;
                    return;
                end
                KEY_CTRL:
                begin
                    ctrl_on = 1'b1;
                    return;
                end
                KEY_ALT:
                begin
                    alt_on = 1'b1;
                    return;
                end
                KEY_CAPS:
                begin
                    caps_on = !caps_on;
                    return;
                end
                default: ;
            endcase
            if (key >= MAP_SIZE)
                return;
            ch = shift_on ? shift_tbl[key] : plain_tbl[key];
            // caps lock flips letter case after the shift lookup
            if (caps_on) begin
                if (ch >= ASCII_LOW_A && ch <= ASCII_LOW_Z)
                    ch = ch - CASE_DELTA;
                else if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z)
                    ch = ch + CASE_DELTA;
            end
            if (ch == ASCII_NUL)
                return;
            if (ch == ASCII_BS)
                push_event(EV_BACKSPACE, ASCII_NUL);
            else if (ch == ASCII_LF)
                push_event(EV_ENTER, ASCII_NUL);
            else
                push_event(EV_CHAR, ch);
        endfunction

        function void check_event(logic [2:0] kind, logic [6:0] code, logic ctrl, logic alt);
            result_t ev;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event kind=%0d code=%h ctrl=%b alt=%b",
                         $time, kind, code, ctrl, alt);
                errors++;
                return;
            end
            ev = expected_events.pop_front();
            if (kind !== ev.kind) begin
                $display("%0t: event_kind expected %0d actual %0d", $time, ev.kind, kind);
                errors++;
            end
            if (code !== ev.char_code) begin
                $display("%0t: char_code expected %h actual %h", $time, ev.char_code, code);
                errors++;
            end
            if (ctrl !== ev.ctrl_held) begin
                $display("%0t: ctrl_held expected %b actual %b", $time, ev.ctrl_held, ctrl);
                errors++;
            end
            if (alt !== ev.alt_held) begin
                $display("%0t: alt_held expected %b actual %b", $time, ev.alt_held, alt);
                errors++;
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] scancode = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] event_kind;
    logic [6:0] char_code;
    logic       ctrl_held;
    logic       alt_held;

    kb_event_scoreboard sb = new();

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_stall = 0;

    keyboard_scancode_to_char_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .scancode   (scancode),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .char_code  (char_code),
        .ctrl_held  (ctrl_held),
        .alt_held   (alt_held)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #6_000_000;
        $display("timeout with %0d events outstanding", sb.pending());
        $display("FAILURE");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(negedge clk)
    begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            out_ready <= 1'b0;
        end else if (rx_burst || $urandom_range(0, 99) < 70) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= 1'b0;
            rx_stall <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_event(event_kind, char_code, ctrl_held, alt_held);
    end

    // Called at a falling edge; returns at a falling edge after the beat and its gap.
    task automatic send_scancode(input logic [7:0] sc);
        int gap;
        in_valid <= 1'b1;
        scancode <= sc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_scancode(sc);
        @(negedge clk);
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            scancode <= $urandom_range(0, 255);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Mostly typing with modifiers coming and going, plus some noise.
    function logic [7:0] pick_scancode();
        int r;
        logic [6:0] mods [4];
        mods = '{KEY_LSHIFT, KEY_RSHIFT, KEY_CTRL, KEY_ALT};
        r = $urandom_range(0, 99);
        if (r < 50)
            return {1'b0, 7'($urandom_range(1, 57))};
        if (r < 60)
            return {1'b0, mods[$urandom_range(0, 3)]};
        if (r < 72)
            return {1'b1, mods[$urandom_range(0, 3)]};
        if (r < 76)
            return {1'b0, KEY_CAPS};
        if (r < 82) begin
            case ($urandom_range(0, 3))
                0: return {1'b0, KEY_UP};
                1: return {1'b0, KEY_DOWN};
                2: return {1'b0, KEY_LEFT};
                default: return {1'b0, KEY_RIGHT};
            endcase
        end
        if (r < 90)
            return {1'b1, 7'($urandom_range(0, 127))};
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        logic [7:0] directed [$];
        directed = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h0F, 8'h0E, 8'h1C,
                     8'h4B, 8'h48, 8'h50,
                     {1'b0, KEY_LSHIFT}, {1'b0, KEY_LSHIFT}, {1'b0, KEY_CAPS},
                     8'h1E, 8'h35, {1'b1, KEY_LSHIFT}, 8'h1E, {1'b1, KEY_CAPS},
                     {1'b0, KEY_CAPS}, {1'b0, KEY_CTRL}, {1'b0, KEY_ALT}, 8'h4D,
                     {1'b1, KEY_CTRL}, {1'b1, KEY_ALT}, {1'b0, KEY_RSHIFT}, 8'h10,
                     {1'b1, KEY_RSHIFT}};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_scancode(directed[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 250 == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            if (n == 700)
                wait_drained();
            send_scancode(pick_scancode());
        end

        wait_drained();
        repeat (10) @(negedge clk);

        if (sb.pending() != 0)
            $display("%0d expected events never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/kbsc_pkg.sv
sv/kbsc_decode.sv
sv/kbsc_out_stage.sv
sv/keyboard_scancode_to_char_top.sv
sv/kbsc_checker.sv
tb/sv/keyboard_scancode_to_char_top_test.sv
